@@ design/bba_pkg.sv @@
`default_nettype none

package bba_pkg;

  // Pool geometry
  localparam int MAX_BLOCKS  = 256;
  localparam int ADDR_WIDTH  = 32;
  localparam int GROUP_BITS  = 8;
  localparam int MAP_BYTES   = MAX_BLOCKS / GROUP_BITS;
  localparam int IDX_W       = $clog2(MAP_BYTES);
  localparam int GRP_W       = IDX_W + 1;
  localparam int BIT_W       = $clog2(GROUP_BITS);
  localparam int LEN_W       = 16;
  localparam int CNT_W       = 9;
  localparam int STATUS_W    = 3;

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_FULL      = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Settled configuration as seen by front and back
  typedef struct packed {
    logic [ADDR_WIDTH-1:0] base;
    logic [LEN_W-1:0]      len;
    logic [GRP_W-1:0]      groups;
  } cfg_t;

  // Classified command
  typedef struct packed {
    logic                  op;
    logic                  too_long;
    logic [ADDR_WIDTH-1:0] rel_addr;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/bba_req_if.sv @@
`default_nettype none

interface bba_req_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [bba_pkg::LEN_W-1:0]      request_length;
  logic [bba_pkg::ADDR_WIDTH-1:0] release_address;

  modport source (output valid, output op, output request_length,
                  output release_address, input ready);
  modport sink   (input valid, input op, input request_length,
                  input release_address, output ready);
endinterface

`default_nettype wire

@@ design/bba_rsp_if.sv @@
`default_nettype none

interface bba_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bba_pkg::STATUS_W-1:0]   status;
  logic [bba_pkg::ADDR_WIDTH-1:0] block_address;

  modport source (output valid, output status, output block_address, input ready);
  modport sink   (input valid, input status, input block_address, output ready);
endinterface

`default_nettype wire

@@ design/bitmap_block_allocator.sv @@
`default_nettype none

// Channel   Dir  Fields                                   Accepted when
// req_i     in   op, request_length, release_address      valid && ready
// rsp_o     out  status, block_address                    valid && ready
// cfg       in   cfg_we_i, cfg_index_i, cfg_data_i        cfg_we_i high
//
// A refused or trivially answered item goes from the queue to the output slot without a scan.
// A scan reads one group of eight blocks at a time, up to block_count/8 groups (at most 32),
// limited by the single read port of the busy map.
// Reset clears the busy map at once; no clearing pass follows.
// A two-entry queue takes items while it has room, even while the back end scans or its result waits.

module bitmap_block_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bba_req_if.sink                          req_i,
  bba_rsp_if.source                        rsp_o,
  input  logic                             cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bba_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [bba_pkg::ADDR_WIDTH-1:0] base_q;
  logic [bba_pkg::LEN_W-1:0]      len_q;
  logic [bba_pkg::CNT_W-1:0]      count_q;
  logic [bba_pkg::GRP_W-1:0]      groups_raw;
  bba_pkg::cfg_t                  cfg;
  logic                           push;
  logic                           pop;
  logic                           full;
  logic                           empty;
  bba_pkg::cmd_t                  cmd_in;
  bba_pkg::cmd_t                  cmd_out;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      len_q   <= bba_pkg::LEN_W'(1);
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bba_pkg::CFG_BASE:   base_q  <= bba_pkg::ADDR_WIDTH'(cfg_data_i);
        bba_pkg::CFG_LENGTH: len_q   <= cfg_data_i[bba_pkg::LEN_W-1:0];
        bba_pkg::CFG_COUNT:  count_q <= cfg_data_i[bba_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Whole groups in use, saturated at the map size.
  assign groups_raw = bba_pkg::GRP_W'(count_q >> bba_pkg::BIT_W);

  always_comb begin
    cfg.base   = base_q;
    cfg.len    = len_q;
    cfg.groups = (groups_raw > bba_pkg::GRP_W'(bba_pkg::MAP_BYTES))
               ? bba_pkg::GRP_W'(bba_pkg::MAP_BYTES) : groups_raw;
  end

  bba_front u_front (
    .req    (req_i),
    .len_i  (len_q),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  bba_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  bba_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .rsp     (rsp_o)
  );

endmodule

`default_nettype wire

@@ design/bba_front.sv @@
`default_nettype none

module bba_front (
  bba_req_if.sink                 req,
  input  logic [bba_pkg::LEN_W-1:0] len_i,
  input  logic                    full_i,
  output logic                    push_o,
  output bba_pkg::cmd_t           cmd_o
);

  // An item is taken whenever the queue has room.
  assign req.ready = ~full_i;
  assign push_o    = req.valid & ~full_i;

  // Classify: an allocate longer than one block is refused before the scan.
  always_comb begin
    cmd_o.op       = req.op;
    cmd_o.too_long = (req.op == bba_pkg::OP_ALLOC) && (req.request_length > len_i);
    cmd_o.rel_addr = req.release_address;
  end

endmodule

`default_nettype wire

@@ design/bba_queue.sv @@
`default_nettype none

module bba_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bba_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bba_pkg::cmd_t cmd_o
);

  bba_pkg::cmd_t                mem_q [bba_pkg::QUEUE_DEPTH];
  logic [bba_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [bba_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [bba_pkg::QPTR_W:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (bba_pkg::QPTR_W+1)'(bba_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ design/bba_back.sv @@
`default_nettype none

module bba_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bba_pkg::cfg_t cfg_i,
  input  logic          empty_i,
  input  bba_pkg::cmd_t cmd_i,
  output logic          pop_o,
  bba_rsp_if.source     rsp
);

  localparam int AW = bba_pkg::ADDR_WIDTH;
  localparam int GB = bba_pkg::GROUP_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                   state_q, state_d;
  bba_pkg::cmd_t                cmd_q, cmd_d;
  logic [bba_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [AW-1:0]                acc_q, acc_d;
  logic                         hit_q, hit_d;
  bba_pkg::status_e             status_q, status_d;
  logic [AW-1:0]                addr_q, addr_d;
  logic [GB-1:0]                busy_q [bba_pkg::MAP_BYTES];
  logic                         rsp_valid_q, rsp_valid_d;
  bba_pkg::status_e             rsp_status_q;
  logic [AW-1:0]                rsp_addr_q;

  logic [GB-1:0]                cur_byte;
  logic [AW-1:0]                lane_addr [GB];
  logic [GB-1:0]                match_mask;
  logic [bba_pkg::BIT_W-1:0]    sel;
  logic                         found;
  logic                         last;
  logic [AW-1:0]                step;
  logic                         map_we;
  logic [GB-1:0]                map_wdata;
  logic                         load;

  assign cur_byte = busy_q[idx_q];
  assign last     = ((bba_pkg::GRP_W'(idx_q) + 1'b1) == cfg_i.groups);
  assign step     = AW'(cfg_i.len) << bba_pkg::BIT_W;

  // One lane per bit of the group: block address and release compare.
  always_comb begin
    for (int k = 0; k < GB; k++) begin
      lane_addr[k]  = acc_q + AW'(cfg_i.len) * AW'(k);
      match_mask[k] = (lane_addr[k] == cmd_q.rel_addr);
    end
  end

  // Lowest clear bit of the current group.
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int b = GB - 1; b >= 0; b--) begin
      if (!cur_byte[b]) begin
        sel   = bba_pkg::BIT_W'(b);
        found = 1'b1;
      end
    end
  end

  // Sequencer: take a command, scan one group a cycle if needed, hand over the result.
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    hit_d     = hit_q;
    status_d  = status_q;
    addr_d    = addr_q;
    pop_o     = 1'b0;
    map_we    = 1'b0;
    map_wdata = cur_byte;
    load      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          cmd_d  = cmd_i;
          idx_d  = '0;
          acc_d  = cfg_i.base;
          hit_d  = 1'b0;
          addr_d = '0;
          if (cmd_i.too_long) begin
            status_d = bba_pkg::ST_TOO_LONG;
            state_d  = S_DONE;
          end else if (cfg_i.groups == '0) begin
            status_d = (cmd_i.op == bba_pkg::OP_ALLOC) ? bba_pkg::ST_FULL
                                                       : bba_pkg::ST_NOT_FOUND;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmd_q.op == bba_pkg::OP_ALLOC) begin
          if (found) begin
            map_we         = 1'b1;
            map_wdata[sel] = 1'b1;
            status_d       = bba_pkg::ST_GRANTED;
            addr_d         = lane_addr[sel];
            state_d        = S_DONE;
          end else if (last) begin
            status_d = bba_pkg::ST_FULL;
            state_d  = S_DONE;
          end else begin
            idx_d = idx_q + 1'b1;
            acc_d = acc_q + step;
          end
        end else begin
          map_we    = 1'b1;
          map_wdata = cur_byte & ~match_mask;
          hit_d     = hit_q | (|match_mask);
          if (last) begin
            status_d = (hit_q | (|match_mask)) ? bba_pkg::ST_RELEASED
                                                : bba_pkg::ST_NOT_FOUND;
            state_d  = S_DONE;
          end else begin
            idx_d = idx_q + 1'b1;
            acc_d = acc_q + step;
          end
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp.ready) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output slot is emptied by the sink and refilled from the sequencer.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  assign rsp.valid         = rsp_valid_q;
  assign rsp.status        = rsp_status_q;
  assign rsp.block_address = rsp_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Busy map, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bba_pkg::MAP_BYTES; i++) begin
        busy_q[i] <= '0;
      end
    end else if (map_we) begin
      busy_q[idx_q] <= map_wdata;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    acc_q    <= acc_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    addr_q   <= addr_d;
    if (load) begin
      rsp_status_q <= status_q;
      rsp_addr_q   <= addr_q;
    end
  end

  // A refused request never reaches the scan.
  a_scan_not_too_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !cmd_q.too_long)
    else $error("scan started on a refused request");

  // The scan stays inside the configured groups.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (bba_pkg::GRP_W'(idx_q) < cfg_i.groups))
    else $error("scan index beyond configured groups");

  // Only a grant carries an address.
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_status_q != bba_pkg::ST_GRANTED)) |-> (rsp_addr_q == '0))
    else $error("non-grant result with nonzero address");

  // A finished result waits while the output slot is held.
  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && rsp_valid_q && !rsp.ready) |=> (state_q == S_DONE))
    else $error("result overwrote a waiting output");

endmodule

`default_nettype wire

@@ tb/bba_alloc_checker.sv @@
`default_nettype none

// Watches the request, response and configuration ports of the allocator,
// keeps its own copy of the busy map and pool settings, and checks every
// response against the oldest outstanding prediction.
module bba_alloc_checker
  import bba_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bba_req_if                    req_mon_i,
  bba_rsp_if                    rsp_mon_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_count_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    status_e               status;
    logic [ADDR_WIDTH-1:0] address;
  } alloc_result_t;

  logic [ADDR_WIDTH-1:0] pool_base  = '0;
  logic [LEN_W-1:0]      pool_len   = LEN_W'(1);
  logic [CNT_W-1:0]      pool_count = '0;
  logic [MAX_BLOCKS-1:0] block_busy = '0;
  alloc_result_t         awaited_results[$];

  // Address of one block under the current pool settings, wrapping at the
  // address width.
  function automatic logic [ADDR_WIDTH-1:0] block_address(int unsigned index);
    return pool_base + ADDR_WIDTH'(index) * ADDR_WIDTH'(pool_len);
  endfunction

  // Serves one request against the model busy map and returns the response
  // the allocator owes for it.
  function automatic alloc_result_t serve_request(logic op, logic [LEN_W-1:0] req_len,
                                                  logic [ADDR_WIDTH-1:0] rel_addr);
    alloc_result_t res;
    int unsigned   blocks;
    bit            hit;
    res.status  = ST_NOT_FOUND;
    res.address = '0;
    hit         = 1'b0;
    // Only whole groups of eight count, and never more than the map holds.
    blocks = 32'(pool_count) >> 3;
    if (blocks > MAP_BYTES) blocks = MAP_BYTES;
    blocks = blocks * GROUP_BITS;
    if (op == OP_ALLOC) begin
      if (req_len > pool_len) begin
        res.status = ST_TOO_LONG;
      end else begin
        res.status = ST_FULL;
        for (int unsigned i = 0; i < blocks; i++) begin
          if (!block_busy[i]) begin
            block_busy[i] = 1'b1;
            res.status    = ST_GRANTED;
            res.address   = block_address(i);
            break;
          end
        end
      end
    end else begin
      // Every configured block at this address is released, aliases included.
      for (int unsigned i = 0; i < blocks; i++) begin
        if (block_address(i) == rel_addr) begin
          block_busy[i] = 1'b0;
          hit           = 1'b1;
        end
      end
      res.status = hit ? ST_RELEASED : ST_NOT_FOUND;
    end
    return res;
  endfunction

  // Sampling on the falling edge: what is seen here is what the next rising
  // edge accepts, since every port changes only on rising edges.
  always @(negedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      pool_base  = '0;
      pool_len   = LEN_W'(1);
      pool_count = '0;
      block_busy = '0;
      awaited_results.delete();
      pending_count_o = 0;
    end else begin
      // Responses are compared first; a response can never belong to a
      // request taken on the same edge.
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= REPORT_LIMIT) begin
            $display("%0t: response with nothing outstanding: status %0d address %h",
                     $time, rsp_mon_i.status, rsp_mon_i.block_address);
          end
        end else begin
          want = awaited_results.pop_front();
          if (rsp_mon_i.status !== want.status || rsp_mon_i.block_address !== want.address)
          begin
            mismatch_count_o++;
            if (mismatch_count_o <= REPORT_LIMIT) begin
              $display("%0t: response mismatch: status exp %0d got %0d, address exp %h got %h",
                       $time, want.status, rsp_mon_i.status, want.address,
                       rsp_mon_i.block_address);
            end
          end
        end
      end

      if (req_mon_i.valid && req_mon_i.ready) begin
        awaited_results.push_back(serve_request(req_mon_i.op, req_mon_i.request_length,
                                                req_mon_i.release_address));
      end

      // Register writes; unknown indexes are dropped.
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BASE:   pool_base  = cfg_data_i[ADDR_WIDTH-1:0];
          CFG_LENGTH: pool_len   = cfg_data_i[LEN_W-1:0];
          CFG_COUNT:  pool_count = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end

      pending_count_o = awaited_results.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_bitmap_block_allocator.sv @@
`default_nettype none

module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned PHASE_COUNT      = 7;
  localparam int unsigned PHASE_ITEMS      = 55;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned FINAL_CYCLES     = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_BASE;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int unsigned mismatch_count;
  int unsigned pending_count;

  // Pool settings as last written, used to aim free items at real blocks.
  logic [ADDR_WIDTH-1:0] cur_base  = '0;
  logic [LEN_W-1:0]      cur_len   = LEN_W'(1);
  logic [CNT_W-1:0]      cur_count = '0;

  // Receiver hold-off request and gap-free stretches.
  bit hold_off_req = 1'b0;
  bit steady_flow  = 1'b0;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  bitmap_block_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  bba_alloc_checker alloc_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon_i        (req_ch),
    .rsp_mon_i        (rsp_ch),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one item from a rising edge and returns on the edge that takes it.
  task automatic send_item(logic op, logic [LEN_W-1:0] req_len, logic [ADDR_WIDTH-1:0] addr);
    bit taken;
    req_ch.valid           <= 1'b1;
    req_ch.op              <= op;
    req_ch.request_length  <= req_len;
    req_ch.release_address <= addr;
    do begin
      @(negedge clk_i);
      taken = req_ch.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic pause_sender();
    int unsigned n;
    n = (hold_off_req || steady_flow) ? 0 : pick_gap();
    if (n != 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Writes all registers back to back, with junk in the unused upper data
  // bits, and ends with a write to an unused index.
  task automatic set_pool(logic [ADDR_WIDTH-1:0] base, logic [LEN_W-1:0] len,
                          logic [CNT_W-1:0] count);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BASE;
    cfg_data_i  <= base;
    @(posedge clk_i);
    cfg_index_i <= CFG_LENGTH;
    cfg_data_i  <= {16'($urandom), len};
    @(posedge clk_i);
    cfg_index_i <= CFG_COUNT;
    cfg_data_i  <= {23'($urandom), count};
    @(posedge clk_i);
    cfg_index_i <= CFG_SPARE;
    cfg_data_i  <= $urandom;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cur_base  = base;
    cur_len   = len;
    cur_count = count;
  endtask

  // Stops offering items and waits until every response has come back.
  task automatic drain_pool(int unsigned settle);
    req_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // One random item: mostly allocations that fit and frees aimed at
  // configured blocks, with some oversize requests and stray addresses.
  task automatic random_item(int unsigned alloc_pct);
    logic                  op;
    logic [LEN_W-1:0]      req_len;
    logic [ADDR_WIDTH-1:0] addr;
    int unsigned           blocks;
    int unsigned           roll;
    blocks = 32'(cur_count) >> 3;
    if (blocks > MAP_BYTES) blocks = MAP_BYTES;
    blocks  = blocks * GROUP_BITS;
    op      = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
    req_len = LEN_W'($urandom);
    addr    = $urandom;
    roll    = $urandom_range(0, 9);
    if (op == OP_ALLOC) begin
      if (roll < 7) req_len = LEN_W'($urandom_range(0, 32'(cur_len)));
      else if (roll == 7) req_len = cur_len + LEN_W'(1);
    end else if (blocks != 0 && roll < 8) begin
      addr = cur_base + ADDR_WIDTH'($urandom_range(0, blocks - 1)) * ADDR_WIDTH'(cur_len);
    end
    send_item(op, req_len, addr);
    pause_sender();
  endtask

  // Response side: open and stall at random, hold off for a long stretch
  // when asked, and stay open during gap-free phases.
  initial begin
    rsp_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      int unsigned n;
      if (hold_off_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (steady_flow) begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        n = pick_gap();
        if (n != 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_bitmap_block_allocator failed");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [ADDR_WIDTH-1:0] base;
    logic [LEN_W-1:0]      len;
    logic [CNT_W-1:0]      count;
    req_ch.valid           = 1'b0;
    req_ch.op              = OP_ALLOC;
    req_ch.request_length  = '0;
    req_ch.release_address = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no blocks configured and a one-byte length limit.
    send_item(OP_ALLOC, LEN_W'(0), $urandom);
    send_item(OP_ALLOC, LEN_W'(2), $urandom);
    send_item(OP_FREE, LEN_W'($urandom), '0);
    drain_pool(SETTLE_CYCLES);

    // One group of eight (count low bits ignored) wrapping past the top of
    // the address space: fill it, overflow it, free twice, probe off-grid.
    set_pool(32'hFFFF_FFF0, LEN_W'(4), CNT_W'(15));
    repeat (8) send_item(OP_ALLOC, LEN_W'(4), $urandom);
    send_item(OP_ALLOC, LEN_W'(1), $urandom);
    send_item(OP_FREE, LEN_W'($urandom), 32'h0);
    send_item(OP_FREE, LEN_W'($urandom), 32'h0);
    send_item(OP_FREE, LEN_W'($urandom), 32'h2);
    send_item(OP_ALLOC, LEN_W'(5), $urandom);
    send_item(OP_ALLOC, LEN_W'(0), $urandom);
    drain_pool(SETTLE_CYCLES);

    // Zero block length with an oversized count: every block aliases the
    // base, so one free releases them all.
    set_pool(32'hFFFF_FFFF, LEN_W'(0), CNT_W'(511));
    send_item(OP_ALLOC, LEN_W'(1), $urandom);
    send_item(OP_ALLOC, LEN_W'(0), $urandom);
    send_item(OP_ALLOC, LEN_W'(0), $urandom);
    send_item(OP_FREE, LEN_W'($urandom), 32'hFFFF_FFFF);
    send_item(OP_ALLOC, LEN_W'(0), $urandom);
    drain_pool(SETTLE_CYCLES);

    // Largest blocks over the full pool; the busy map carries over.
    set_pool('0, LEN_W'(16'hFFFF), CNT_W'(256));
    send_item(OP_ALLOC, LEN_W'(16'hFFFF), $urandom);
    send_item(OP_FREE, LEN_W'($urandom), 32'hFFFF_FFFF);
    drain_pool(SETTLE_CYCLES);

    // Random phases, each under fresh settings. The first holds the
    // receiver off for a long stretch; the second runs without gaps.
    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = 32'hFFFF_FFFF - ADDR_WIDTH'($urandom_range(0, 255));
        default: base = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0:       len = '0;
        1:       len = LEN_W'(16'hFFFF);
        2:       len = LEN_W'(1);
        3:       len = LEN_W'($urandom_range(1, 65535));
        default: len = LEN_W'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 7))
        0:       count = '0;
        1:       count = CNT_W'(256);
        2:       count = CNT_W'($urandom);
        default: count = CNT_W'($urandom_range(8, 40));
      endcase
      set_pool(base, len, count);
      hold_off_req = (phase == 0);
      steady_flow  = (phase == 1);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) random_item($urandom_range(35, 75));
      steady_flow = 1'b0;
      drain_pool(SETTLE_CYCLES);
    end

    drain_pool(FINAL_CYCLES);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_bitmap_block_allocator passed");
    end else begin
      $display("tb_bitmap_block_allocator failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/bba_pkg.sv
design/bba_req_if.sv
design/bba_rsp_if.sv
design/bba_front.sv
design/bba_queue.sv
design/bba_back.sv
design/bitmap_block_allocator.sv
tb/bba_alloc_checker.sv
tb/tb_bitmap_block_allocator.sv
